// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL that checks its own logic (rv32_register_taint_tracker).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, disabled while reset is held.
`define RTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check, written as an implication from a trigger to a consequence.
`define RTT_ASSERT_IMP(lbl, trig, cons, msg) \
  `RTT_ASSERT(lbl, (trig) |-> (cons), msg)

`endif

// ===== rtl/rtt_pkg.sv =====
package rtt_pkg;

  localparam int Xlen   = 32;
  localparam int CountW = 16;

  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;

  localparam logic [2:0] KIND_OTHER  = 3'd0;
  localparam logic [2:0] KIND_BRANCH = 3'd1;
  localparam logic [2:0] KIND_LOAD   = 3'd2;
  localparam logic [2:0] KIND_OPIMM  = 3'd3;
  localparam logic [2:0] KIND_OP     = 3'd4;
  localparam logic [2:0] KIND_CLEAR  = 3'd5;

  localparam logic [1:0] CFG_TAINT_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_FORCE_ENABLE   = 2'd1;
  localparam logic [1:0] CFG_SOURCE_ADDRESS = 2'd2;

  localparam logic [Xlen-1:0]   SRC_ADDR_RESET = 32'h8000_1000;
  localparam logic [CountW-1:0] COUNT_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [2:0]      kind;
    logic [4:0]      rd;
    logic [4:0]      rs1;
    logic [4:0]      rs2;
    logic            load_hit;
    logic [Xlen-1:0] taken_pc;
    logic [Xlen-1:0] fall_pc;
  } dec_t;

  typedef struct packed {
    logic [Xlen-1:0]   fork_fall_pc;
    logic [Xlen-1:0]   fork_taken_pc;
    logic              fork_valid;
    logic [CountW-1:0] tainted_branch_count;
    logic              branch_tainted;
  } res_t;

endpackage

// ===== rtl/rtt_decode.sv =====
module rtt_decode import rtt_pkg::*; (
  input  logic [Xlen-1:0] instr,
  input  logic [Xlen-1:0] instr_pc,
  input  logic [Xlen-1:0] base_value,
  input  logic            taint_enable,
  input  logic [Xlen-1:0] source_address,
  output dec_t            dec
);

  logic [Xlen-1:0] imm_i;
  logic [Xlen-1:0] imm_b;
  logic [Xlen-1:0] load_addr;

  assign imm_i = {{20{instr[31]}}, instr[31:20]};
  assign imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
  assign load_addr = base_value + imm_i;

  always_comb begin
    case (instr[6:0])
      OPC_BRANCH: dec.kind = KIND_BRANCH;
      OPC_LOAD:   dec.kind = KIND_LOAD;
      OPC_OPIMM:  dec.kind = KIND_OPIMM;
      OPC_OP:     dec.kind = KIND_OP;
      OPC_LUI:    dec.kind = KIND_CLEAR;
      OPC_AUIPC:  dec.kind = KIND_CLEAR;
      default:    dec.kind = KIND_OTHER;
    endcase
    dec.rd       = instr[11:7];
    dec.rs1      = instr[19:15];
    dec.rs2      = instr[24:20];
    dec.load_hit = taint_enable && (load_addr == source_address);
    dec.taken_pc = instr_pc + imm_b;
    dec.fall_pc  = instr_pc + 32'd4;
  end

endmodule

// ===== rtl/rtt_taint_file.sv =====
module rtt_taint_file import rtt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  dec_t dec,
  output logic rs1_taint,
  output logic rs2_taint
);

  logic [31:0] taint_r;
  logic [31:0] taint_nxt;
  logic        wr_en;
  logic        wr_bit;

  assign rs1_taint = taint_r[dec.rs1];
  assign rs2_taint = taint_r[dec.rs2];

  always_comb begin
    wr_en  = 1'b1;
    wr_bit = 1'b0;
    case (dec.kind)
      KIND_LOAD:  wr_bit = dec.load_hit;
      KIND_OPIMM: wr_bit = rs1_taint;
      KIND_OP:    wr_bit = rs1_taint | rs2_taint;
      KIND_CLEAR: wr_bit = 1'b0;
      default:    wr_en  = 1'b0;
    endcase
    taint_nxt = taint_r;
    if (wr_en) begin
      taint_nxt[dec.rd] = wr_bit;
    end
    // x0 can never carry taint.
    taint_nxt[0] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taint_r <= '0;
    end else if (fire) begin
      taint_r <= taint_nxt;
    end
  end

endmodule

// ===== rtl/rtt_branch_tracker.sv =====
module rtt_branch_tracker import rtt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic fire,
  input  dec_t dec,
  input  logic src_taint,
  input  logic force_enable,
  output res_t st,
  output res_t nxt
);

  logic [CountW-1:0] count_r;
  logic              fork_r;
  logic [Xlen-1:0]   taken_r;
  logic [Xlen-1:0]   fall_r;
  logic              flagged;
  logic              capture;

  assign flagged = (dec.kind == KIND_BRANCH) && src_taint;
  assign capture = flagged && force_enable && !fork_r;

  always_comb begin
    st.branch_tainted       = 1'b0;
    st.tainted_branch_count = count_r;
    st.fork_valid           = fork_r;
    st.fork_taken_pc        = taken_r;
    st.fork_fall_pc         = fall_r;

    nxt = st;
    nxt.branch_tainted = flagged;
    if (flagged && (count_r != COUNT_MAX)) begin
      nxt.tainted_branch_count = count_r + 16'd1;
    end
    if (capture) begin
      nxt.fork_valid    = 1'b1;
      nxt.fork_taken_pc = dec.taken_pc;
      nxt.fork_fall_pc  = dec.fall_pc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      fork_r  <= 1'b0;
      taken_r <= '0;
      fall_r  <= '0;
    end else if (fire) begin
      count_r <= nxt.tainted_branch_count;
      fork_r  <= nxt.fork_valid;
      taken_r <= nxt.fork_taken_pc;
      fall_r  <= nxt.fork_fall_pc;
    end
  end

endmodule

// ===== rtl/rv32_register_taint_tracker.sv =====
// Channel   Direction  Payload (tdata, lowest bit first)
// in_*      slave      instr[31:0], instr_pc[63:32], base_value[95:64]
// out_*     master     branch_tainted, tainted_branch_count, fork_valid,
//                      fork_taken_pc, fork_fall_pc, zero pad to 88 bits
// cfg_*     write      index 0 taint_enable, 1 force_enable, 2 source_address
//
// One instruction per cycle is sustained while the output is not stalled; an instruction
// passes an input register, then the decode, taint file update and result register.
// The taint bits and branch state update in the cycle an instruction moves
// from the input register into the result register, so back-to-back
// instructions see each other's effects. Reset is synchronous and active low.
// A stalled output holds the input register; the input then stalls once full.
`include "assert_macros.svh"

module rv32_register_taint_tracker import rtt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // instr, instr_pc, base_value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // branch_tainted, tainted_branch_count, fork_valid,
                                  // fork_taken_pc, fork_fall_pc, zero pad
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic            taint_en_r;
  logic            force_en_r;
  logic [Xlen-1:0] src_addr_r;

  logic            s1_valid_r;
  logic [Xlen-1:0] s1_instr_r;
  logic [Xlen-1:0] s1_pc_r;
  logic [Xlen-1:0] s1_base_r;

  logic            out_valid_r;
  res_t            res_r;

  logic            adv;
  dec_t            dec;
  logic            rs1_taint;
  logic            rs2_taint;
  res_t            trk_st;
  res_t            trk_nxt;

  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taint_en_r <= 1'b1;
      force_en_r <= 1'b1;
      src_addr_r <= SRC_ADDR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TAINT_ENABLE:   taint_en_r <= cfg_data[0];
        CFG_FORCE_ENABLE:   force_en_r <= cfg_data[0];
        CFG_SOURCE_ADDRESS: src_addr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_instr_r <= in_tdata[31:0];
      s1_pc_r    <= in_tdata[63:32];
      s1_base_r  <= in_tdata[95:64];
    end
  end

  rtt_decode u_decode (
    .instr          (s1_instr_r),
    .instr_pc       (s1_pc_r),
    .base_value     (s1_base_r),
    .taint_enable   (taint_en_r),
    .source_address (src_addr_r),
    .dec            (dec)
  );

  rtt_taint_file u_taint_file (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (adv),
    .dec       (dec),
    .rs1_taint (rs1_taint),
    .rs2_taint (rs2_taint)
  );

  rtt_branch_tracker u_branch_tracker (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (adv),
    .dec          (dec),
    .src_taint    (rs1_taint | rs2_taint),
    .force_enable (force_en_r),
    .st           (trk_st),
    .nxt          (trk_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_r <= trk_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, res_r};

  `RTT_ASSERT_IMP(a_count_monotonic, $past(rst_n),
    trk_st.tainted_branch_count >= $past(trk_st.tainted_branch_count),
    "Tainted branch count decreased.")
  `RTT_ASSERT(a_fork_sticky, trk_st.fork_valid |=> trk_st.fork_valid,
    "Fork capture was lost.")
  `RTT_ASSERT(a_count_step,
    (adv && trk_nxt.branch_tainted && (trk_st.tainted_branch_count != COUNT_MAX))
      |=> (trk_st.tainted_branch_count == $past(trk_st.tainted_branch_count) + 16'd1),
    "Tainted branch did not advance the count.")
  `RTT_ASSERT_IMP(a_stall_full, !in_tready, s1_valid_r && out_valid_r,
    "Input stalled with a free stage.")

endmodule

// ===== sim/rv32_register_taint_tracker_tb.sv =====
module rv32_register_taint_tracker_tb;
  import rtt_pkg::*;

  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] OPC_JAL     = 7'h6F;
  localparam logic [6:0] OPC_JALR    = 7'h67;
  localparam logic [6:0] OPC_SYSTEM  = 7'h73;
  localparam logic [6:0] OPC_UNKNOWN = 7'h7F;
  localparam logic [1:0] CFG_UNUSED  = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [95:0] in_tdata = '0;  // instr, instr_pc, base_value
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [87:0] out_tdata;      // branch_tainted, tainted_branch_count, fork_valid,
                               // fork_taken_pc, fork_fall_pc, zero pad
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  rv32_register_taint_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the tracker state and its configuration.
  logic [31:0]       shadow_taint = '0;
  logic [CountW-1:0] flag_count = '0;
  logic              fork_held = 1'b0;
  logic [31:0]       taken_tgt = '0;
  logic [31:0]       fall_tgt = '0;
  logic              taint_en = 1'b1;
  logic              force_en = 1'b1;
  logic [31:0]       source_addr = SRC_ADDR_RESET;

  res_t expected_q[$];
  int   errors = 0;
  bit   src_quiet = 1'b0;
  bit   sink_quiet = 1'b0;
  logic sink_hold = 1'b0;
  int   sink_wait = 0;

  function automatic res_t predict_retire(logic [31:0] instr, logic [31:0] pc,
                                          logic [31:0] base);
    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_b;
    res_t        r;
    rd    = instr[11:7];
    rs1   = instr[19:15];
    rs2   = instr[24:20];
    imm_i = {{20{instr[31]}}, instr[31:20]};
    imm_b = {{19{instr[31]}}, instr[31], instr[7], instr[30:25], instr[11:8], 1'b0};
    r.branch_tainted = 1'b0;
    case (instr[6:0])
      OPC_BRANCH: begin
        if (shadow_taint[rs1] || shadow_taint[rs2]) begin
          r.branch_tainted = 1'b1;
          if (flag_count != COUNT_MAX) flag_count = flag_count + 16'd1;
          if (force_en && !fork_held) begin
            fork_held = 1'b1;
            taken_tgt = pc + imm_b;
            fall_tgt  = pc + 32'd4;
          end
        end
      end
      OPC_LOAD:              shadow_taint[rd] = taint_en && (base + imm_i == source_addr);
      OPC_OPIMM:             shadow_taint[rd] = shadow_taint[rs1];
      OPC_OP:                shadow_taint[rd] = shadow_taint[rs1] || shadow_taint[rs2];
      OPC_LUI, OPC_AUIPC:    shadow_taint[rd] = 1'b0;
      default: ;
    endcase
    shadow_taint[0] = 1'b0;
    r.tainted_branch_count = flag_count;
    r.fork_valid           = fork_held;
    r.fork_taken_pc        = taken_tgt;
    r.fork_fall_pc         = fall_tgt;
    return r;
  endfunction

  function automatic logic [31:0] enc_i(logic [6:0] opc, logic [4:0] rd, logic [4:0] rs1,
                                        logic [11:0] imm);
    return {imm, rs1, 3'($urandom_range(0, 7)), rd, opc};
  endfunction

  function automatic logic [31:0] enc_r(logic [6:0] opc, logic [4:0] rd, logic [4:0] rs1,
                                        logic [4:0] rs2);
    return {7'($urandom), rs2, rs1, 3'($urandom_range(0, 7)), rd, opc};
  endfunction

  function automatic logic [31:0] enc_b(logic [4:0] rs1, logic [4:0] rs2, logic [12:0] off);
    return {off[12], off[10:5], rs2, rs1, 3'($urandom_range(0, 7)), off[4:1], off[11],
            OPC_BRANCH};
  endfunction

  function automatic logic [4:0] pick_reg();
    return ($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 7)) : 5'($urandom);
  endfunction

  task automatic send_retire(input logic [31:0] instr, input logic [31:0] pc,
                             input logic [31:0] base);
    int gap;
    gap = src_quiet ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {base, pc, instr};
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(predict_retire(instr, pc, base));
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input logic te, input logic fe, input logic [31:0] sa);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TAINT_ENABLE;
    cfg_data  <= {31'($urandom), te};
    @(posedge clk);
    cfg_index <= CFG_FORCE_ENABLE;
    cfg_data  <= {31'($urandom), fe};
    @(posedge clk);
    cfg_index <= CFG_SOURCE_ADDRESS;
    cfg_data  <= sa;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_we <= 1'b0;
    taint_en    = te;
    force_en    = fe;
    source_addr = sa;
  endtask

  task automatic random_retire();
    logic [31:0] w;
    logic [31:0] pc;
    logic [31:0] base;
    int          pick;
    w    = $urandom;
    pc   = $urandom;
    base = $urandom;
    pick = $urandom_range(0, 99);
    w[11:7]  = pick_reg();
    w[19:15] = pick_reg();
    w[24:20] = pick_reg();
    if (pick < 20) begin
      w[6:0] = OPC_LOAD;
      if ($urandom_range(0, 2) != 0) base = source_addr - {{20{w[31]}}, w[31:20]};
    end else if (pick < 33) begin
      w[6:0] = OPC_OPIMM;
    end else if (pick < 46) begin
      w[6:0] = OPC_OP;
    end else if (pick < 50) begin
      w[6:0] = OPC_LUI;
    end else if (pick < 54) begin
      w[6:0] = OPC_AUIPC;
    end else if (pick < 84) begin
      w[6:0] = OPC_BRANCH;
    end else if (pick < 92) begin
      case ($urandom_range(0, 3))
        0: w[6:0] = OPC_STORE;
        1: w[6:0] = OPC_JAL;
        2: w[6:0] = OPC_JALR;
        default: w[6:0] = OPC_SYSTEM;
      endcase
    end
    if ($urandom_range(0, 7) == 0) begin
      pc = $urandom_range(0, 1) ? {20'hFFFFF, pc[11:0]} : {20'h00000, pc[11:0]};
    end
    send_retire(w, pc, base);
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (out_tvalid && out_tready) begin
      got = res_t'(out_tdata[81:0]);
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing expected: %h", out_tdata);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (got.branch_tainted !== want.branch_tainted) begin
          $error("branch_tainted: expected %0d, got %0d", want.branch_tainted,
                 got.branch_tainted);
          errors++;
        end
        if (got.tainted_branch_count !== want.tainted_branch_count) begin
          $error("tainted_branch_count: expected %0d, got %0d", want.tainted_branch_count,
                 got.tainted_branch_count);
          errors++;
        end
        if (got.fork_valid !== want.fork_valid) begin
          $error("fork_valid: expected %0d, got %0d", want.fork_valid, got.fork_valid);
          errors++;
        end
        if (got.fork_taken_pc !== want.fork_taken_pc) begin
          $error("fork_taken_pc: expected %h, got %h", want.fork_taken_pc, got.fork_taken_pc);
          errors++;
        end
        if (got.fork_fall_pc !== want.fork_fall_pc) begin
          $error("fork_fall_pc: expected %h, got %h", want.fork_fall_pc, got.fork_fall_pc);
          errors++;
        end
      end
      sink_wait = sink_quiet ? 0 : $urandom_range(0, 17);
    end else if (sink_wait != 0) begin
      sink_wait = sink_wait - 1;
    end
    out_tready <= rst_n && !sink_hold && sink_wait == 0;
  end

  task automatic test_taint_sources();
    send_retire(enc_r(OPC_LUI, 5'd5, 5'($urandom), 5'($urandom)), 32'h0000_0100, $urandom);
    send_retire(enc_b(5'd1, 5'd2, 13'h0010), 32'h0000_0104, $urandom);
    send_retire(enc_i(OPC_LOAD, 5'd1, 5'd2, 12'h7FF), 32'h0000_0108,
                SRC_ADDR_RESET - 32'h7FF);
    send_retire(enc_i(OPC_LOAD, 5'd2, 5'd3, 12'h800), 32'h0000_010C,
                SRC_ADDR_RESET + 32'h800);
    send_retire(enc_i(OPC_LOAD, 5'd0, 5'd3, 12'h000), 32'h0000_0110, SRC_ADDR_RESET);
    send_retire(enc_i(OPC_OPIMM, 5'd3, 5'd1, 12'hFFF), 32'h0000_0114, $urandom);
    send_retire(enc_r(OPC_OP, 5'd4, 5'd0, 5'd3), 32'h0000_0118, $urandom);
    send_retire(enc_r(OPC_AUIPC, 5'd2, 5'($urandom), 5'($urandom)), 32'h0000_011C, $urandom);
    send_retire(enc_i(OPC_LOAD, 5'd1, 5'd2, 12'h7FF), 32'h0000_0120,
                SRC_ADDR_RESET - 32'h7FE);
    send_retire(enc_r(OPC_OP, 5'd7, 5'd1, 5'd2), 32'h0000_0124, $urandom);
    wait_idle();
  endtask

  task automatic test_fork_capture();
    configure(1'b1, 1'b0, SRC_ADDR_RESET);
    send_retire(enc_b(5'd4, 5'd0, 13'h0020), 32'h0000_0200, $urandom);
    send_retire(enc_b(5'd7, 5'd3, 13'h1FFE), 32'h0000_0204, $urandom);
    wait_idle();
    configure(1'b1, 1'b1, SRC_ADDR_RESET);
    send_retire(enc_b(5'd0, 5'd0, 13'h0040), 32'h0000_0208, $urandom);
    send_retire(enc_b(5'd3, 5'd7, 13'h1000), 32'h0000_0800, $urandom);
    send_retire(enc_b(5'd0, 5'd4, 13'h0FFE), 32'hFFFF_FFFC, $urandom);
    wait_idle();
  endtask

  task automatic test_other_opcodes();
    send_retire(enc_r(OPC_STORE, 5'd4, 5'd0, 5'd0), 32'h0000_0300, $urandom);
    send_retire(enc_r(OPC_JAL, 5'd4, 5'd0, 5'd0), 32'h0000_0304, $urandom);
    send_retire(enc_r(OPC_JALR, 5'd4, 5'd0, 5'd0), 32'h0000_0308, $urandom);
    send_retire(enc_r(OPC_SYSTEM, 5'd4, 5'd0, 5'd0), 32'h0000_030C, $urandom);
    send_retire(enc_r(OPC_UNKNOWN, 5'd5, 5'd4, 5'd4), 32'h0000_0310, $urandom);
    send_retire(enc_b(5'd5, 5'd4, 13'h0008), 32'h0000_0314, $urandom);
    send_retire(enc_r(OPC_LUI, 5'd4, 5'($urandom), 5'($urandom)), 32'h0000_0318, $urandom);
    send_retire(enc_b(5'd4, 5'd0, 13'h0008), 32'h0000_031C, $urandom);
    wait_idle();
  endtask

  task automatic test_taint_disabled();
    configure(1'b0, 1'b1, SRC_ADDR_RESET);
    send_retire(enc_i(OPC_LOAD, 5'd6, 5'd1, 12'h000), 32'h0000_0400, SRC_ADDR_RESET);
    send_retire(enc_b(5'd6, 5'd6, 13'h0004), 32'h0000_0404, $urandom);
    wait_idle();
    configure(1'b1, 1'b1, 32'hFFFF_FFFF);
    send_retire(enc_i(OPC_LOAD, 5'd6, 5'd1, 12'hFFF), 32'h0000_0408, 32'h0000_0000);
    send_retire(enc_b(5'd6, 5'd0, 13'h0004), 32'h0000_040C, $urandom);
    wait_idle();
  endtask

  task automatic test_backpressure();
    src_quiet = 1'b1;
    fork
      begin
        sink_hold <= 1'b1;
        repeat (80) @(posedge clk);
        sink_hold <= 1'b0;
      end
    join_none
    for (int i = 0; i < 40; i++) random_retire();
    src_quiet = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: configure(1'b1, 1'b1, 32'h0000_0000);
        1: configure(1'b0, 1'b0, 32'hFFFF_FFFF);
        2: configure(1'b1, 1'b0, 32'hFFFF_FFFF);
        3: configure(1'b1, 1'b1, $urandom);
        default: configure(1'b1, 1'b1, SRC_ADDR_RESET);
      endcase
      for (int i = 0; i < 220; i++) begin
        if (i % 20 == 0) begin
          src_quiet  = ($urandom_range(0, 3) == 0);
          sink_quiet = ($urandom_range(0, 3) == 0);
        end
        random_retire();
      end
      src_quiet  = 1'b0;
      sink_quiet = 1'b0;
      wait_idle();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_taint_sources();
    test_fork_capture();
    test_other_opcodes();
    test_taint_disabled();
    test_backpressure();
    test_random_traffic();
    if (errors == 0) begin
      $display("rv32_register_taint_tracker_tb OK");
    end else begin
      $display("rv32_register_taint_tracker_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("rv32_register_taint_tracker_tb NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rtt_pkg.sv
rtl/rtt_decode.sv
rtl/rtt_taint_file.sv
rtl/rtt_branch_tracker.sv
rtl/rv32_register_taint_tracker.sv
sim/rv32_register_taint_tracker_tb.sv
